@@ rtl/alpha_over_compositor_assert.svh @@
// Assertion macros for the alpha-over compositor.
`ifndef ALPHA_OVER_COMPOSITOR_ASSERT_SVH
`define ALPHA_OVER_COMPOSITOR_ASSERT_SVH

// Plain implication, checked every clock while out of reset.
`define AOC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alpha_over_compositor assertion failed");

// Implication with a fixed latency between the two sides.
`define AOC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("alpha_over_compositor latency check failed");

`endif

@@ rtl/aoc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package aoc_pkg;

  localparam int unsigned Full8  = 255;
  localparam int unsigned Full16 = 65025;

  localparam logic [7:0] RegOpacity = 8'd0;
  localparam logic [7:0] RegVisible = 8'd1;

  // front stages, divider stages, output register
  localparam int unsigned FrontLat = 3;
  localparam int unsigned DivLat   = 8;
  localparam int unsigned TotalLat = FrontLat + DivLat + 1;

  // floor(T / 65025) == (T * AlphaRecip) >> AlphaShift for every T < 2^24
  localparam logic [24:0] AlphaRecip = 25'd16909061;
  localparam int unsigned AlphaShift = 40;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // front end result: divisor, numerators and bypass data
  typedef struct packed {
    logic        pass;
    logic [23:0] den;
    logic [31:0] num_r;
    logic [31:0] num_g;
    logic [31:0] num_b;
    pix_out_t    dst;
  } blend_t;

endpackage
`default_nettype wire

@@ rtl/aoc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module aoc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire aoc_pkg::pix_in_t pix_i,
  input  wire logic [7:0]      opacity_i,
  input  wire logic            visible_i,
  output logic                 valid_o,
  output aoc_pkg::blend_t      blend_o
);
  import aoc_pkg::*;

  logic [2:0] vld_q;

  // stage 1: S = a_s * opacity
  pix_in_t     pix1_q;
  logic [15:0] s1_q;
  logic        inv1_q;
  // stage 2: W = a_d*(65025-S), X = c_s*S
  pix_in_t     pix2_q;
  logic [15:0] s2_q;
  logic        inv2_q;
  logic [23:0] w2_q, xr2_q, xg2_q, xb2_q;
  // stage 3
  blend_t      b3_q;

  logic [23:0] t3_d;
  logic [31:0] nr3_d, ng3_d, nb3_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign t3_d   = 24'({8'd0, s2_q, 8'd0} - {16'd0, s2_q}) + w2_q;
  assign nr3_d  = ({xr2_q, 8'd0} - {8'd0, xr2_q}) + 32'(pix2_q.dst_red) * 32'(w2_q);
  assign ng3_d  = ({xg2_q, 8'd0} - {8'd0, xg2_q}) + 32'(pix2_q.dst_green) * 32'(w2_q);
  assign nb3_d  = ({xb2_q, 8'd0} - {8'd0, xb2_q}) + 32'(pix2_q.dst_blue) * 32'(w2_q);

  always_ff @(posedge clk_i) begin
    pix1_q <= pix_i;
    s1_q   <= 16'(pix_i.src_alpha) * 16'(opacity_i);
    inv1_q <= ~visible_i;

    pix2_q <= pix1_q;
    s2_q   <= s1_q;
    inv2_q <= inv1_q;
    w2_q   <= 24'(pix1_q.dst_alpha) * 24'(16'(Full16) - s1_q);
    xr2_q  <= 24'(pix1_q.src_red) * 24'(s1_q);
    xg2_q  <= 24'(pix1_q.src_green) * 24'(s1_q);
    xb2_q  <= 24'(pix1_q.src_blue) * 24'(s1_q);

    b3_q.pass  <= inv2_q || (t3_d == '0);
    b3_q.den   <= t3_d;
    b3_q.num_r <= nr3_d;
    b3_q.num_g <= ng3_d;
    b3_q.num_b <= nb3_d;
    b3_q.dst   <= {pix2_q.dst_red, pix2_q.dst_green, pix2_q.dst_blue, pix2_q.dst_alpha};
  end

  assign valid_o = vld_q[2];
  assign blend_o = b3_q;
endmodule
`default_nettype wire

@@ rtl/aoc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module aoc_div (
  input  wire logic        clk_i,
  input  wire logic [31:0] num_i,
  input  wire logic [23:0] den_i,
  output logic [7:0]       quo_o
);
  import aoc_pkg::*;

  // restoring division, one quotient bit per stage; quotient known < 256
  logic [31:0] rem_q [DivLat-1];
  logic [23:0] den_q [DivLat-1];
  logic [7:0]  quo_q [DivLat];
  logic [32:0] st_c  [DivLat];

  // {take, remainder after the trial subtract}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic [23:0] den,
                                           int unsigned sh);
    logic [31:0] trial;
    trial = 32'(den) << sh;
    if (rem >= trial) begin
      return {1'b1, rem - trial};
    end
    return {1'b0, rem};
  endfunction

  always_comb begin
    st_c[0] = div_step(num_i, den_i, DivLat - 1);
    for (int i = 1; i < DivLat; i++) begin
      st_c[i] = div_step(rem_q[i-1], den_q[i-1], DivLat - 1 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= st_c[0][31:0];
    den_q[0] <= den_i;
    quo_q[0] <= 8'(st_c[0][32]) << (DivLat - 1);
    for (int i = 1; i < DivLat - 1; i++) begin
      rem_q[i] <= st_c[i][31:0];
      den_q[i] <= den_q[i-1];
    end
    for (int i = 1; i < DivLat; i++) begin
      quo_q[i] <= quo_q[i-1] | (8'(st_c[i][32]) << (DivLat - 1 - i));
    end
  end

  assign quo_o = quo_q[DivLat-1];
endmodule
`default_nettype wire

@@ rtl/alpha_over_compositor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Source-over blend of straight-alpha RGBA8 pixels with layer opacity.
// Input: start/busy command channel carrying in_i (source and destination
//   pixel). A beat is taken on every clock where start is high and busy is
//   low; busy never rises, so one pixel per clock is sustained.
// Output: out_valid_o strobes for one cycle with out_o. The receiver has no
//   way to hold off; every beat must be captured in its strobe cycle.
// Pipeline: 12 register stages from an accepted beat to its strobe: three
//   front stages (opacity multiply, cross products, numerators and divisor),
//   eight restoring divider stages (one quotient bit each, lanes R, G and B;
//   alpha is T/65025 by a reciprocal multiply delayed to match), one output
//   register. Throughput one beat per clock, set by the fully pipelined lanes.
// Config: cfg_valid_i/cfg_ready_o write channel, cfg_index_i selects
//   layer_opacity (0) or layer_visible (1); other indexes are dropped.
//   Write only while the pipe is empty.
// Reset: opacity 255, visible 1, pipeline empty. Invisible layer or zero
//   output alpha passes the destination pixel through.
module alpha_over_compositor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire aoc_pkg::pix_in_t  in_i,
  output logic                   out_valid_o,
  output aoc_pkg::pix_out_t      out_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [7:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);
  import aoc_pkg::*;
  `include "alpha_over_compositor_assert.svh"

  logic [7:0] opacity_q;
  logic       visible_q;
  logic       accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= 8'(Full8);
      visible_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegOpacity) begin
        opacity_q <= cfg_data_i;
      end else if (cfg_index_i == RegVisible) begin
        visible_q <= cfg_data_i[0];
      end
    end
  end

  // front end: multiplies down to divisor T and three numerators
  logic   f_valid;
  blend_t f_blend;

  aoc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .pix_i    (in_i),
    .opacity_i(opacity_q),
    .visible_i(visible_q),
    .valid_o  (f_valid),
    .blend_o  (f_blend)
  );

  // divider lanes
  logic [7:0] q_r, q_g, q_b, q_a;

  aoc_div u_div_r (.clk_i(clk_i), .num_i(f_blend.num_r), .den_i(f_blend.den), .quo_o(q_r));
  aoc_div u_div_g (.clk_i(clk_i), .num_i(f_blend.num_g), .den_i(f_blend.den), .quo_o(q_g));
  aoc_div u_div_b (.clk_i(clk_i), .num_i(f_blend.num_b), .den_i(f_blend.den), .quo_o(q_b));

  // alpha = T / 65025: one multiply stage, then delay to the divider depth
  logic [48:0] a_prod_q;
  logic [7:0]  a_dly_q [DivLat-1];

  always_ff @(posedge clk_i) begin
    a_prod_q   <= 49'(f_blend.den) * 49'(AlphaRecip);
    a_dly_q[0] <= a_prod_q[AlphaShift +: 8];
    for (int i = 1; i < DivLat - 1; i++) begin
      a_dly_q[i] <= a_dly_q[i-1];
    end
  end

  assign q_a = a_dly_q[DivLat-2];

  // bypass data rides alongside the divider
  logic [DivLat-1:0] vld_q;
  logic [DivLat-1:0] pass_q;
  pix_out_t          dst_q [DivLat];
  logic              out_vld_q;
  pix_out_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[DivLat-2:0], f_valid};
      out_vld_q <= vld_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q   <= {pass_q[DivLat-2:0], f_blend.pass};
    dst_q[0] <= f_blend.dst;
    for (int i = 1; i < DivLat; i++) begin
      dst_q[i] <= dst_q[i-1];
    end
    out_q <= pass_q[DivLat-1] ? dst_q[DivLat-1] : {q_r, q_g, q_b, q_a};
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // every accepted beat comes out as an out_valid_o strobe
  `AOC_ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, TotalLat, out_valid_o)
  // a strobe needs a matching accept at the pipeline input
  `AOC_ASSERT_IMPL(a_no_phantom, clk_i, rst_ni, out_valid_o, $past(accept, TotalLat))
  // hidden layer passes destination alpha through
  `AOC_ASSERT_IMPL(a_hidden_pass, clk_i, rst_ni, out_valid_o && !visible_q,
                   out_o.out_alpha == $past(in_i.dst_alpha, TotalLat))
endmodule
`default_nettype wire
